[hw/rtl/clt_pkg.sv]
// ----------------------------------------------------------------------------
// clt_pkg: shared types, state codes and lookup functions
// Holds the result and step types, the DFA state codes and the character
// class and transition functions used by the C token lexer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // DFA state codes; 49 and 50 are unused.
  typedef enum logic [5:0] {
    ST_START = 6'd0, ST_F, ST_FO, ST_FOR, ST_W, ST_WH, ST_WHI, ST_WHIL, ST_WHILE,
    ST_I, ST_IF, ST_E, ST_EL, ST_ELS, ST_ELSE, ST_IDENT,
    ST_PLUS, ST_INC, ST_PLUS_EQ, ST_MINUS, ST_DEC, ST_MINUS_EQ, ST_STAR, ST_STAR_EQ,
    ST_SLASH, ST_SLASH_EQ, ST_ASSIGN, ST_EQ, ST_GT, ST_GE, ST_SHR, ST_LT, ST_LE,
    ST_SHL, ST_BANG, ST_NE, ST_BOR, ST_LOR, ST_OR_EQ, ST_BAND, ST_LAND, ST_AND_EQ,
    ST_XOR, ST_XOR_EQ, ST_LPAREN, ST_LBRACE, ST_RPAREN, ST_RBRACE, ST_SPACE,
    ST_NUM = 6'd51, ST_NUM_SP, ST_ERROR
  } dfa_state_t;

  // Byte that acts as end of stream.
  localparam logic [7:0] CH_EOS = 8'd255;

  // Default depth of the result queue.
  localparam int FIFO_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic [5:0] state_code;
    logic       is_final;
  } result_t;

  // Transition outcome of a non-START state.
  typedef struct packed {
    logic       bt;
    logic [5:0] state;
  } adv_t;

  // Everything one character produces.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    logic [5:0] state;
    logic       started;
  } step_t;

  // Status of the result queue seen by the top level.
  typedef struct packed {
    logic room;
    logic empty;
  } fifo_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // State reached from START on one character.
  function automatic logic [5:0] from_start(input logic [7:0] c);
    logic [5:0] s;
    case (c) inside
      "f":      s = ST_F;
      "w":      s = ST_W;
      "i":      s = ST_I;
      "e":      s = ST_E;
      "+":      s = ST_PLUS;
      "-":      s = ST_MINUS;
      "*":      s = ST_STAR;
      "/":      s = ST_SLASH;
      "=":      s = ST_ASSIGN;
      ";", ",": s = ST_START;
      ">":      s = ST_GT;
      "<":      s = ST_LT;
      "!":      s = ST_BANG;
      "|":      s = ST_BOR;
      "&":      s = ST_BAND;
      "^":      s = ST_XOR;
      "(":      s = ST_LPAREN;
      "{":      s = ST_LBRACE;
      ")":      s = ST_RPAREN;
      "}":      s = ST_RBRACE;
      " ":      s = ST_SPACE;
      default: begin
        if (is_alpha(c) || (c == "_")) begin
          s = ST_IDENT;
        end else if (is_digit(c)) begin
          s = ST_NUM;
        end else begin
          s = ST_START;
        end
      end
    endcase
    return s;
  endfunction

  // Next state of a state other than START, or a backtrack request.
  function automatic adv_t advance(input logic [5:0] s, input logic [7:0] c);
    adv_t r;
    r.bt    = 1'b1;
    r.state = ST_START;
    case (s) inside
      ST_F:    if (c == "o") r = '{bt: 1'b0, state: ST_FO};
      ST_FO:   if (c == "r") r = '{bt: 1'b0, state: ST_FOR};
      ST_W:    if (c == "h") r = '{bt: 1'b0, state: ST_WH};
      ST_WH:   if (c == "i") r = '{bt: 1'b0, state: ST_WHI};
      ST_WHI:  if (c == "l") r = '{bt: 1'b0, state: ST_WHIL};
      ST_WHIL: if (c == "e") r = '{bt: 1'b0, state: ST_WHILE};
      ST_I:    if (c == "f") r = '{bt: 1'b0, state: ST_IF};
      ST_E:    if (c == "l") r = '{bt: 1'b0, state: ST_EL};
      ST_EL:   if (c == "s") r = '{bt: 1'b0, state: ST_ELS};
      ST_ELS:  if (c == "e") r = '{bt: 1'b0, state: ST_ELSE};
      ST_IDENT: begin
        if (is_alpha(c) || is_digit(c) || (c == "_")) r = '{bt: 1'b0, state: ST_IDENT};
      end
      ST_PLUS: begin
        if (c == "+") r = '{bt: 1'b0, state: ST_INC};
        else if (c == "=") r = '{bt: 1'b0, state: ST_PLUS_EQ};
      end
      ST_MINUS: begin
        if (c == "-") r = '{bt: 1'b0, state: ST_DEC};
        else if (c == "=") r = '{bt: 1'b0, state: ST_MINUS_EQ};
      end
      ST_STAR:   if (c == "=") r = '{bt: 1'b0, state: ST_STAR_EQ};
      ST_SLASH:  if (c == "=") r = '{bt: 1'b0, state: ST_SLASH_EQ};
      ST_ASSIGN: if (c == "=") r = '{bt: 1'b0, state: ST_EQ};
      ST_GT: begin
        if (c == "=") r = '{bt: 1'b0, state: ST_GE};
        else if (c == ">") r = '{bt: 1'b0, state: ST_SHR};
      end
      ST_LT: begin
        if (c == "=") r = '{bt: 1'b0, state: ST_LE};
        else if (c == "<") r = '{bt: 1'b0, state: ST_SHL};
      end
      ST_BANG: if (c == "=") r = '{bt: 1'b0, state: ST_NE};
      ST_BOR: begin
        if (c == "|") r = '{bt: 1'b0, state: ST_LOR};
        else if (c == "=") r = '{bt: 1'b0, state: ST_OR_EQ};
      end
      ST_BAND: begin
        if (c == "&") r = '{bt: 1'b0, state: ST_LAND};
        else if (c == "=") r = '{bt: 1'b0, state: ST_AND_EQ};
      end
      ST_XOR:   if (c == "=") r = '{bt: 1'b0, state: ST_XOR_EQ};
      ST_SPACE: if (c == " ") r = '{bt: 1'b0, state: ST_SPACE};
      ST_NUM: begin
        if (is_digit(c)) begin
          r = '{bt: 1'b0, state: ST_NUM};
        end else if (c == " ") begin
          r = '{bt: 1'b0, state: ST_NUM_SP};
        end else if (is_alpha(c) || (c == "(") || (c == "{") || (c == "[") ||
                     (c == "=") || (c == "_")) begin
          r = '{bt: 1'b0, state: ST_ERROR};
        end
      end
      ST_NUM_SP: begin
        if (is_digit(c) || (c == "=")) r = '{bt: 1'b0, state: ST_ERROR};
      end
      ST_FOR, ST_WHILE, ST_IF, ST_ELSE, ST_INC, ST_PLUS_EQ, ST_DEC, ST_MINUS_EQ,
      ST_STAR_EQ, ST_SLASH_EQ, ST_EQ, ST_GE, ST_SHR, ST_LE, ST_SHL, ST_NE,
      ST_LOR, ST_OR_EQ, ST_LAND, ST_AND_EQ, ST_XOR_EQ, ST_LPAREN, ST_LBRACE,
      ST_RPAREN, ST_RBRACE: r.bt = 1'b1;
      // The error trap and unused codes hold their value.
      default: r = '{bt: 1'b0, state: s};
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/clt_step.sv]
// ----------------------------------------------------------------------------
// clt_step: per-character transition logic
// Works out the next DFA state and the zero, one or two result items that
// one character produces, including the backtrack to START.
// ----------------------------------------------------------------------------
module clt_step (
  input  logic [7:0]      ch,
  input  logic            end_of_stream,
  input  logic [5:0]      state,
  input  logic            started,
  output clt_pkg::step_t  step
);

  clt_pkg::adv_t adv;
  logic [5:0]    restart;

  assign adv     = clt_pkg::advance(state, ch);
  assign restart = clt_pkg::from_start(ch);

  // Select the results and the state that the character leaves behind.
  always_comb begin
    step.count   = 2'd0;
    step.res0    = '{state_code: clt_pkg::ST_START, is_final: 1'b0};
    step.res1    = '{state_code: restart, is_final: 1'b0};
    step.state   = state;
    step.started = 1'b1;
    if (end_of_stream || (ch == clt_pkg::CH_EOS)) begin
      // Final report, then back to the reset state.
      step.count   = 2'd1;
      step.res0    = '{state_code: state, is_final: 1'b1};
      step.state   = clt_pkg::ST_START;
      step.started = 1'b0;
    end else if (state == clt_pkg::ST_START) begin
      step.state = restart;
      step.res0  = '{state_code: restart, is_final: 1'b0};
      if (!started || (restart != clt_pkg::ST_START)) begin
        step.count = 2'd1;
      end
    end else if (adv.bt) begin
      // Report START, then rerun the character from START.
      step.state = restart;
      if (restart != clt_pkg::ST_START) begin
        step.count = 2'd2;
      end else begin
        step.count = 2'd1;
      end
    end else begin
      step.state = adv.state;
      step.res0  = '{state_code: adv.state, is_final: 1'b0};
      if (!started || (adv.state != state)) begin
        step.count = 2'd1;
      end
    end
  end

endmodule

[hw/rtl/clt_fifo.sv]
// ----------------------------------------------------------------------------
// clt_fifo: result queue
// Small register queue that takes up to two results per cycle and hands
// out one per output request from a registered head entry.
// ----------------------------------------------------------------------------
module clt_fifo #(
  parameter int DEPTH = clt_pkg::FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_n,
  input  clt_pkg::result_t      push0,
  input  clt_pkg::result_t      push1,
  input  logic                  out_ready,
  output clt_pkg::result_t      head,
  output clt_pkg::fifo_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clt_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_p1, wr_p2;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign wr_p1 = ptr_inc(wr_ptr_r);
  assign wr_p2 = ptr_inc(wr_p1);
  assign pop   = out_ready && (count_r != '0);

  // Pointer and fill count updates.
  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_p1;
      2'd2:    wr_ptr_nxt = wr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= push1;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.room  = (count_r <= CNT_W'(DEPTH - 2));

endmodule

[hw/rtl/c_token_dfa_lexer.sv]
// ----------------------------------------------------------------------------
// c_token_dfa_lexer: C token lexer DFA
// Takes one character per request, runs the 52-state lexer automaton and
// reports every change of state, plus a final report at end of stream.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result queue has room; the
// output side drains one result per cycle while out_ready is high, so a
// backtrack that yields two results costs the queue a slot. The input
// stalls while the result queue has fewer than two free entries.
// Reset: synchronous active-low rst_n returns the DFA to START, clears the
// trace-started flag and empties the input stage and the result queue.
module c_token_dfa_lexer #(
  parameter int FIFO_DEPTH = clt_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_state_code,
  output logic       out_is_final
);

  logic                  stg_vld_r, stg_vld_nxt;
  logic [7:0]            stg_ch_r;
  logic                  stg_eos_r;
  clt_pkg::dfa_state_t   dfa_state_r;
  logic                  started_r;
  logic                  fire;
  logic [1:0]            push_n;
  clt_pkg::step_t        step;
  clt_pkg::result_t      head;
  clt_pkg::fifo_status_t fstat;

  // The staged character moves on once the queue has room for two results.
  assign fire        = stg_vld_r && fstat.room;
  assign in_ready    = !stg_vld_r || fire;
  assign stg_vld_nxt = in_ready ? in_valid : stg_vld_r;
  assign push_n      = fire ? step.count : 2'd0;

  // Input stage control and DFA state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r   <= 1'b0;
      dfa_state_r <= clt_pkg::ST_START;
      started_r   <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      if (fire) begin
        dfa_state_r <= clt_pkg::dfa_state_t'(step.state);
        started_r   <= step.started;
      end
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_ch_r  <= in_ch;
      stg_eos_r <= in_end_of_stream;
    end
  end

  clt_step u_step (
    .ch            (stg_ch_r),
    .end_of_stream (stg_eos_r),
    .state         (dfa_state_r),
    .started       (started_r),
    .step          (step)
  );

  clt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (step.res0),
    .push1     (step.res1),
    .out_ready (out_ready),
    .head      (head),
    .status    (fstat)
  );

  assign out_valid      = !fstat.empty;
  assign out_state_code = head.state_code;
  assign out_is_final   = head.is_final;

  // Codes 49, 50 and above ERROR are never entered.
  a_state_legal : assert property (@(posedge clk) disable iff (!rst_n)
    (dfa_state_r <= clt_pkg::ST_SPACE) ||
    ((dfa_state_r >= clt_pkg::ST_NUM) && (dfa_state_r <= clt_pkg::ST_ERROR)))
    else $error("DFA entered an unused state code");

  // Before the first report the DFA must still be in START.
  a_start_before_trace : assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (dfa_state_r == clt_pkg::ST_START))
    else $error("DFA left START without starting the trace");

  // End of stream returns the DFA to its reset state.
  a_eos_resets : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (stg_eos_r || (stg_ch_r == clt_pkg::CH_EOS)))
    |=> ((dfa_state_r == clt_pkg::ST_START) && !started_r))
    else $error("End of stream did not reset the DFA");

  // A staged character that cannot move on holds its value.
  a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !fire) |=> (stg_vld_r && $stable(stg_ch_r) && $stable(stg_eos_r)))
    else $error("Stalled input stage lost its character");

endmodule

[test/c_token_dfa_lexer_tb.sv]
// ----------------------------------------------------------------------------
// c_token_dfa_lexer_tb: self-checking testbench for the C token lexer
// Streams directed and random C-like text through the lexer with bursty
// input traffic and a stalling receiver. A scoreboard predicts every state
// report and compares it, field by field, with what leaves the block.
// ----------------------------------------------------------------------------

// Tracks the lexer state and holds the state reports still to come out.
class lexer_scoreboard;
  clt_pkg::dfa_state_t cur_state;
  bit                  reported;
  clt_pkg::result_t    report_q[$];
  int                  errors;

  function new();
    cur_state = clt_pkg::ST_START;
    reported  = 1'b0;
    errors    = 0;
  endfunction

  function bit is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function bit is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // State that START moves to on one character.
  function clt_pkg::dfa_state_t start_target(logic [7:0] c);
    case (c)
      "f": return clt_pkg::ST_F;
      "w": return clt_pkg::ST_W;
      "i": return clt_pkg::ST_I;
      "e": return clt_pkg::ST_E;
      "+": return clt_pkg::ST_PLUS;
      "-": return clt_pkg::ST_MINUS;
      "*": return clt_pkg::ST_STAR;
      "/": return clt_pkg::ST_SLASH;
      "=": return clt_pkg::ST_ASSIGN;
      ">": return clt_pkg::ST_GT;
      "<": return clt_pkg::ST_LT;
      "!": return clt_pkg::ST_BANG;
      "|": return clt_pkg::ST_BOR;
      "&": return clt_pkg::ST_BAND;
      "^": return clt_pkg::ST_XOR;
      "(": return clt_pkg::ST_LPAREN;
      "{": return clt_pkg::ST_LBRACE;
      ")": return clt_pkg::ST_RPAREN;
      "}": return clt_pkg::ST_RBRACE;
      " ": return clt_pkg::ST_SPACE;
      default: ;
    endcase
    if (is_letter(c) || (c == "_")) return clt_pkg::ST_IDENT;
    if (is_digit(c)) return clt_pkg::ST_NUM;
    // Separators and every other byte leave START where it is.
    return clt_pkg::ST_START;
  endfunction

  // Next state from a state other than START; bt is set when the state
  // cannot take the character and the lexer has to back up.
  function clt_pkg::dfa_state_t next_target(clt_pkg::dfa_state_t s, logic [7:0] c,
                                            output bit bt);
    clt_pkg::dfa_state_t r;
    r = clt_pkg::ST_START;
    case (s)
      clt_pkg::ST_F:    if (c == "o") r = clt_pkg::ST_FO;
      clt_pkg::ST_FO:   if (c == "r") r = clt_pkg::ST_FOR;
      clt_pkg::ST_W:    if (c == "h") r = clt_pkg::ST_WH;
      clt_pkg::ST_WH:   if (c == "i") r = clt_pkg::ST_WHI;
      clt_pkg::ST_WHI:  if (c == "l") r = clt_pkg::ST_WHIL;
      clt_pkg::ST_WHIL: if (c == "e") r = clt_pkg::ST_WHILE;
      clt_pkg::ST_I:    if (c == "f") r = clt_pkg::ST_IF;
      clt_pkg::ST_E:    if (c == "l") r = clt_pkg::ST_EL;
      clt_pkg::ST_EL:   if (c == "s") r = clt_pkg::ST_ELS;
      clt_pkg::ST_ELS:  if (c == "e") r = clt_pkg::ST_ELSE;
      clt_pkg::ST_IDENT: begin
        if (is_letter(c) || is_digit(c) || (c == "_")) r = clt_pkg::ST_IDENT;
      end
      clt_pkg::ST_PLUS: begin
        if (c == "+") r = clt_pkg::ST_INC;
        else if (c == "=") r = clt_pkg::ST_PLUS_EQ;
      end
      clt_pkg::ST_MINUS: begin
        if (c == "-") r = clt_pkg::ST_DEC;
        else if (c == "=") r = clt_pkg::ST_MINUS_EQ;
      end
      clt_pkg::ST_STAR:   if (c == "=") r = clt_pkg::ST_STAR_EQ;
      clt_pkg::ST_SLASH:  if (c == "=") r = clt_pkg::ST_SLASH_EQ;
      clt_pkg::ST_ASSIGN: if (c == "=") r = clt_pkg::ST_EQ;
      clt_pkg::ST_GT: begin
        if (c == "=") r = clt_pkg::ST_GE;
        else if (c == ">") r = clt_pkg::ST_SHR;
      end
      clt_pkg::ST_LT: begin
        if (c == "=") r = clt_pkg::ST_LE;
        else if (c == "<") r = clt_pkg::ST_SHL;
      end
      clt_pkg::ST_BANG: if (c == "=") r = clt_pkg::ST_NE;
      clt_pkg::ST_BOR: begin
        if (c == "|") r = clt_pkg::ST_LOR;
        else if (c == "=") r = clt_pkg::ST_OR_EQ;
      end
      clt_pkg::ST_BAND: begin
        if (c == "&") r = clt_pkg::ST_LAND;
        else if (c == "=") r = clt_pkg::ST_AND_EQ;
      end
      clt_pkg::ST_XOR:   if (c == "=") r = clt_pkg::ST_XOR_EQ;
      clt_pkg::ST_SPACE: if (c == " ") r = clt_pkg::ST_SPACE;
      clt_pkg::ST_NUM: begin
        if (is_digit(c)) r = clt_pkg::ST_NUM;
        else if (c == " ") r = clt_pkg::ST_NUM_SP;
        else if (is_letter(c) || (c == "(") || (c == "{") || (c == "[") ||
                 (c == "=") || (c == "_")) r = clt_pkg::ST_ERROR;
      end
      clt_pkg::ST_NUM_SP: if (is_digit(c) || (c == "=")) r = clt_pkg::ST_ERROR;
      // The error state is a trap until end of stream.
      clt_pkg::ST_ERROR: r = clt_pkg::ST_ERROR;
      // Complete tokens take no further character.
      default: ;
    endcase
    // No state other than START leads back to START without backing up.
    bt = (r == clt_pkg::ST_START);
    return r;
  endfunction

  function void push_report(logic [5:0] code, logic fin);
    clt_pkg::result_t r;
    r.state_code = code;
    r.is_final   = fin;
    report_q.push_back(r);
  endfunction

  // Notes an accepted request and queues the reports it causes.
  function void note_request(logic [7:0] c, logic eos);
    clt_pkg::dfa_state_t prev;
    clt_pkg::dfa_state_t nxt;
    bit                  bt;
    if (eos || (c == clt_pkg::CH_EOS)) begin
      push_report(cur_state, 1'b1);
      cur_state = clt_pkg::ST_START;
      reported  = 1'b0;
      return;
    end
    prev = cur_state;
    if (prev == clt_pkg::ST_START) begin
      nxt = start_target(c);
    end else begin
      nxt = next_target(prev, c, bt);
      // Back up: report START and run the same character from START.
      if (bt) begin
        push_report(clt_pkg::ST_START, 1'b0);
        reported = 1'b1;
        prev     = clt_pkg::ST_START;
        nxt      = start_target(c);
      end
    end
    if (!reported || (nxt != prev)) push_report(nxt, 1'b0);
    reported  = 1'b1;
    cur_state = nxt;
  endfunction

  function int pending();
    return report_q.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Compares one state report with the oldest one predicted.
  task check_result(logic [5:0] code, logic fin);
    clt_pkg::result_t want;
    if (report_q.size() == 0) begin
      report_mismatch($sformatf("unpredicted report state %0d final %0b", code, fin));
      return;
    end
    want = report_q.pop_front();
    if (code !== want.state_code)
      report_mismatch($sformatf("state %0d, predicted %0d", code, want.state_code));
    if (fin !== want.is_final)
      report_mismatch($sformatf("final flag %0b, predicted %0b", fin, want.is_final));
  endtask
endclass

module c_token_dfa_lexer_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_CHARS = 1700;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'd0;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] out_state_code;
  logic       out_is_final;

  lexer_scoreboard sb;

  int          cycles = 0;
  int          in_count = 0;
  int          chars_sent = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [15:0] rx_mask = 16'hFFFF;
  logic [5:0]  rx_phase = 6'd0;

  string lead_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digit_chars = "0123456789";
  string num_tails = "7=x;(";
  string op_tokens[] = '{"for", "while", "if", "else", "fo", "whil", "els",
                         "+", "++", "+=", "-", "--", "-=", "*", "*=", "/", "/=",
                         "=", "==", ">", ">=", ">>", "<", "<=", "<<", "!", "!=",
                         "|", "||", "|=", "&", "&&", "&=", "^", "^=", "(", "{",
                         ")", "}", "[", "]", " ", "  ", ";", ","};

  c_token_dfa_lexer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_state_code  (out_state_code),
    .out_is_final    (out_is_final)
  );

  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL c_token_dfa_lexer");
      $finish;
    end
  end

  // Note every accepted request and check every accepted report.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_ch, in_end_of_stream);
        in_count <= in_count + 1;
      end
      if (out_valid && out_ready) sb.check_result(out_state_code, out_is_final);
    end
  end

  // Receiver: a stall mask that is redrawn each time its phase counter wraps,
  // plus one long hold-off once traffic is under way so the block backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && (in_count >= 400)) begin
      out_ready <= 1'b0;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      rx_phase  <= rx_phase + 6'd1;
      out_ready <= rx_mask[rx_phase[3:0]];
      if (rx_phase == 6'd63) begin
        if ($urandom_range(0, 3) == 0) rx_mask <= 16'hFFFF;
        else rx_mask <= 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      end
    end
  end

  // Offers one character and waits until it is accepted; between bursts
  // the sender may drop valid for a random gap.
  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    in_valid         <= 1'b1;
    in_ch            <= c;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(0, 25);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Stops sending until every predicted report has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random token: mostly well-formed text, some noise and stream ends.
  task automatic send_token();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_text(op_tokens[$urandom_range(0, op_tokens.size() - 1)]);
    end else if (pick < 70) begin
      n = $urandom_range(0, 5);
      send_char(lead_chars[$urandom_range(0, lead_chars.len() - 1)], 1'b0);
      repeat (n) send_char(word_chars[$urandom_range(0, word_chars.len() - 1)], 1'b0);
    end else if (pick < 82) begin
      // Numbers, sometimes followed by what drives them into the error trap.
      n = $urandom_range(1, 4);
      repeat (n) send_char(digit_chars[$urandom_range(0, 9)], 1'b0);
      n = $urandom_range(0, 9);
      if (n < 3) begin
        send_char(" ", 1'b0);
        send_char(num_tails[$urandom_range(0, num_tails.len() - 1)], 1'b0);
      end else if (n < 5) begin
        send_char(lead_chars[$urandom_range(0, lead_chars.len() - 1)], 1'b0);
      end
    end else if (pick < 92) begin
      send_char(8'($urandom_range(0, 254)), 1'b0);
    end else if ($urandom_range(0, 1) == 0) begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_char(clt_pkg::CH_EOS, 1'b0);
    end
  endtask

  initial begin
    bit mid_pause_done;
    sb = new();
    mid_pause_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unknown first byte, a keyword, bang backing up, the number
    // error path and its trap, both ways to end a stream, separators and
    // bytes outside the character classes.
    send_char("#", 1'b0);
    send_text("for(!x1 9 7a");
    send_char(clt_pkg::CH_EOS, 1'b0);
    send_char(",", 1'b0);
    send_char(8'd200, 1'b0);
    send_char(8'd0, 1'b0);
    send_text("<<;");
    send_char("w", 1'b1);
    send_char(clt_pkg::CH_EOS, 1'b1);
    drain();

    // Random token stream with one full pause midway.
    while (chars_sent < TARGET_CHARS) begin
      send_token();
      if (!mid_pause_done && (chars_sent >= 900)) begin
        drain();
        mid_pause_done = 1'b1;
      end
    end
    drain();
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) sb.report_mismatch("predicted reports never came out");
    if (sb.errors == 0) begin
      $display("PASS c_token_dfa_lexer");
    end else begin
      $display("FAIL c_token_dfa_lexer");
    end
    $finish;
  end

endmodule
